// ----- rtl/core/pbs3_pkg.sv -----
`default_nettype none

package pbs3_pkg;

  localparam int MAX_SIDE = 16;
  localparam int SIDE_MIN = 3;
  localparam int SIDE_RESET = 16;
  localparam int AXIS_W = $clog2(MAX_SIDE);
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int ADDR_W = 3 * AXIS_W;
  localparam int CFG_W = 5;
  localparam int SAMPLE_W = 16;
  localparam int SMOOTH_W = 22;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [1:0] DIG_MINUS = 2'd0;
  localparam logic [1:0] DIG_MID = 2'd1;
  localparam logic [1:0] DIG_PLUS = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_GATHER,
    ST_LAST
  } state_t;

  function automatic logic [AXIS_W-1:0] wrap_step(
    input logic [AXIS_W-1:0] c,
    input logic [1:0] d,
    input logic [SIDE_W-1:0] side
  );
    logic [SIDE_W-1:0] side_m1;
    logic [SIDE_W-1:0] c_p1;
    logic [AXIS_W-1:0] res;
    side_m1 = side - 1'b1;
    c_p1 = SIDE_W'(c) + 1'b1;
    case (d)
      DIG_MINUS: res = (c == '0) ? side_m1[AXIS_W-1:0] : c - 1'b1;
      DIG_PLUS: res = (c_p1 >= side) ? '0 : c_p1[AXIS_W-1:0];
      default: res = c;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/periodic_binomial_smooth_3d_core.sv -----
// channel   ports                                       handshake
// ------------------------------------------------------------------------
// command   cmd cell_x cell_y cell_z sample             start & !busy
// result    smoothed coord_error                        done (one cycle)
// config    cfg_wdata (grid_side)                       cfg_we
//
// A read makes 27 grid reads through the single memory port, one per cycle,
// then the last state adds the final tap once its read data returns, and done
// is raised as the core goes back to idle.
// The next word is accepted in the cycle done is high.
// A write or a read with a bad coordinate is finished from the idle state.
// After reset all 4096 cells of the grid are swept to zero with busy high.
// The receiver cannot stall; done is never held.
`default_nettype none

module periodic_binomial_smooth_3d_core
  import pbs3_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       cmd,
  input  wire logic [AXIS_W-1:0]          cell_x,
  input  wire logic [AXIS_W-1:0]          cell_y,
  input  wire logic [AXIS_W-1:0]          cell_z,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_W-1:0]           cfg_wdata,
  output logic                            done,
  output logic signed [SMOOTH_W-1:0]      smoothed,
  output logic                            coord_error
);

  state_t state, state_next;

  logic [CFG_W-1:0]    grid_side;
  logic [SIDE_W-1:0]   side_use;
  logic [ADDR_W-1:0]   clr_addr;
  logic [AXIS_W-1:0]   px, py, pz;
  logic [1:0]          dx, dy, dz;
  logic [1:0]          sh_d;
  logic                rd_valid;
  logic signed [SMOOTH_W-1:0] acc;
  logic signed [SMOOTH_W-1:0] term;
  logic signed [SMOOTH_W-1:0] acc_sum;
  logic [1:0]          shift;
  logic                bad;
  logic                accept;
  logic                last_tap;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_addr;
  logic [SAMPLE_W-1:0] mem_wdata;
  logic [SAMPLE_W-1:0] mem_rdata;

  pbs3_ram #(
    .ADDR_BITS(ADDR_W),
    .DATA_BITS(SAMPLE_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  always_comb begin
    if (grid_side < CFG_W'(SIDE_MIN)) begin
      side_use = SIDE_W'(SIDE_MIN);
    end else if (32'(grid_side) > MAX_SIDE) begin
      side_use = SIDE_W'(MAX_SIDE);
    end else begin
      side_use = SIDE_W'(grid_side);
    end
  end

  assign bad = (SIDE_W'(cell_x) >= side_use) || (SIDE_W'(cell_y) >= side_use) ||
               (SIDE_W'(cell_z) >= side_use);
  assign accept = start && !busy;
  assign last_tap = (dx == DIG_PLUS) && (dy == DIG_PLUS) && (dz == DIG_PLUS);
  assign shift = 2'(dx == DIG_MID) + 2'(dy == DIG_MID) + 2'(dz == DIG_MID);
  assign term = {{(SMOOTH_W - SAMPLE_W){mem_rdata[SAMPLE_W-1]}}, mem_rdata} <<< sh_d;
  assign acc_sum = acc + term;

  always_comb begin
    state_next = state;
    busy = 1'b1;
    mem_we = 1'b0;
    mem_addr = {cell_x, cell_y, cell_z};
    mem_wdata = sample;
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_addr = clr_addr;
        mem_wdata = '0;
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        mem_we = start && (cmd == CMD_WRITE) && !bad;
        if (start && (cmd == CMD_READ) && !bad) begin
          state_next = ST_GATHER;
        end
      end
      ST_GATHER: begin
        mem_addr = {wrap_step(px, dx, side_use), wrap_step(py, dy, side_use),
                    wrap_step(pz, dz, side_use)};
        if (last_tap) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      grid_side <= CFG_W'(SIDE_RESET);
      done <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        grid_side <= cfg_wdata;
      end
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == ST_GATHER) begin
        rd_valid <= 1'b1;
      end else begin
        rd_valid <= 1'b0;
      end
      done <= (state == ST_LAST) || (accept && (cmd == CMD_READ) && bad);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px <= cell_x;
      py <= cell_y;
      pz <= cell_z;
      dx <= DIG_MINUS;
      dy <= DIG_MINUS;
      dz <= DIG_MINUS;
      acc <= '0;
      if (cmd == CMD_READ && bad) begin
        smoothed <= '0;
        coord_error <= 1'b1;
      end
    end
    if (state == ST_GATHER) begin
      sh_d <= shift;
      if (rd_valid) begin
        acc <= acc_sum;
      end
      if (dz == DIG_PLUS) begin
        dz <= DIG_MINUS;
        if (dy == DIG_PLUS) begin
          dy <= DIG_MINUS;
          dx <= dx + 1'b1;
        end else begin
          dy <= dy + 1'b1;
        end
      end else begin
        dz <= dz + 1'b1;
      end
    end
    if (state == ST_LAST) begin
      smoothed <= acc_sum;
      coord_error <= 1'b0;
    end
  end

  a_last_has_data: assert property (@(posedge clk) disable iff (rst)
    state == ST_LAST |-> rd_valid)
    else $error("final tap without read data");

  a_no_write_in_gather: assert property (@(posedge clk) disable iff (rst)
    state == ST_GATHER |-> !mem_we)
    else $error("memory write during gather");

  a_good_done_after_last: assert property (@(posedge clk) disable iff (rst)
    done && !coord_error |-> $past(state == ST_LAST))
    else $error("result without completed gather");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    done && coord_error |-> smoothed == '0)
    else $error("error result not zero");

endmodule

`default_nettype wire

// ----- rtl/core/pbs3_ram.sv -----
`default_nettype none

module pbs3_ram #(
  parameter int ADDR_BITS = 12,
  parameter int DATA_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] addr,
  input  wire logic [DATA_BITS-1:0] wdata,
  output logic      [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire
